// ----- src/ssp_pkg.sv -----
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, codes and reset values for the sequential servo pulse
// generator.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int unsigned CHANNELS_DEF = 8;

    localparam int unsigned WIDTH_W = 16;
    localparam int unsigned STEP_W  = 12;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CHSEL_W = 3;

    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RAMP = 2'd3;

    localparam logic [WIDTH_W-1:0] SLOT_RESET  = 16'd2500;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 12'd10;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 16'd1500;

    typedef struct packed {
        logic [WIDTH_W-1:0] width;
        logic [WIDTH_W-1:0] target;
        logic               active;
        logic               upward;
    } t_lane;

    typedef struct packed {
        logic               sel;
        logic               set;
        logic               ramp;
        logic [WIDTH_W-1:0] value;
        logic [STEP_W-1:0]  step;
    } t_lane_ctl;

endpackage

// ----- src/ssp_lane.sv -----
// ----------------------------------------------------------------------------
// ssp_lane
// Per-channel width, target and ramp state with saturating step update.
// ----------------------------------------------------------------------------
module ssp_lane
    import ssp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_lane_ctl i_ctl,
    output t_lane     o_state,
    output t_lane     o_next
);

    t_lane              r_state;
    t_lane              n_state;
    logic [WIDTH_W:0]   up_sum;
    logic [WIDTH_W-1:0] up_w;
    logic [WIDTH_W-1:0] step_ext;
    logic [WIDTH_W-1:0] dn_w;

    assign step_ext = {{(WIDTH_W-STEP_W){1'b0}}, i_ctl.step};
    assign up_sum   = {1'b0, r_state.width} + {1'b0, step_ext};
    assign up_w     = up_sum[WIDTH_W] ? {WIDTH_W{1'b1}} : up_sum[WIDTH_W-1:0];
    assign dn_w     = (r_state.width > step_ext) ? (r_state.width - step_ext)
                                                 : '0;

    always_comb begin
        n_state = r_state;
        if (i_ctl.sel) begin
            n_state.target = i_ctl.value;
            if (i_ctl.set) begin
                n_state.width  = i_ctl.value;
                n_state.active = 1'b0;
            end else if (i_ctl.value == r_state.width) begin
                n_state.active = 1'b0;
            end else begin
                n_state.active = 1'b1;
                n_state.upward = i_ctl.value > r_state.width;
            end
        end else if (i_ctl.ramp && r_state.active) begin
            if (r_state.upward) begin
                n_state.width = up_w;
                if (up_w >= r_state.target) n_state.active = 1'b0;
            end else begin
                n_state.width = dn_w;
                if (dn_w <= r_state.target) n_state.active = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.width  <= WIDTH_RESET;
            r_state.target <= WIDTH_RESET;
            r_state.active <= 1'b0;
            r_state.upward <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;
    assign o_next  = n_state;

endmodule

// ----- src/sequential_servo_pulse_generator.sv -----
// ----------------------------------------------------------------------------
// sequential_servo_pulse_generator
// Slot-sequenced servo pulse generator with per-channel width ramping.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-----------------------------------
//   s_      | in  | s_tvalid / s_tready   | tuser: cmd; tdata: channel, value
//   m_      | out | m_tvalid / m_tready   | tdata: lines, slot, moving mask
//   apb     | in  | psel/penable/pready   | slot_period @0x0, step_size @0x4
//
// Each beat is processed in the cycle it is accepted; the status beat is
// registered and valid on the next cycle; one beat per cycle while m_tready is high.
// The slot counter compare and the per-lane step adders set the path.
// s_tready drops only while a status beat waits and m_tready is low.
// Synchronous active-low reset restores all widths and targets to center.
// ----------------------------------------------------------------------------
module sequential_servo_pulse_generator
    import ssp_pkg::*;
#(
    parameter int unsigned CHANNELS = CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // channel[2:0], value[18:3], zero[23:19]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // servo_lines[7:0], slot_channel[10:8],
                                   // moving_mask[18:11], zero[23:19]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [WIDTH_W-1:0] r_slot;
    logic [STEP_W-1:0]  r_step;
    logic [WIDTH_W-1:0] r_tick;
    logic [WIDTH_W-1:0] n_tick;
    logic [CH_W-1:0]    r_cur;
    logic [CH_W-1:0]    n_cur;
    logic [WIDTH_W-1:0] r_latch;
    logic [WIDTH_W-1:0] n_latch;
    logic               r_line;
    logic               n_line;
    logic               r_m_valid;
    logic [23:0]        r_m_data;
    logic [23:0]        n_m_data;

    logic               acc;
    logic [CMD_W-1:0]   in_cmd;
    logic [CHSEL_W-1:0] in_ch;
    logic [WIDTH_W-1:0] in_value;
    logic [WIDTH_W-1:0] tick_inc;
    logic               cfg_wr;

    t_lane              lane_q [CHANNELS];
    t_lane              lane_n [CHANNELS];
    t_lane_ctl          lane_ctl [CHANNELS];
    logic [CHANNELS-1:0] act_n;
    logic [CHANNELS+7:0] act_pad;
    logic [CH_W+2:0]    cur_pad;
    logic [7:0]         lines;

    assign in_cmd   = s_tuser;
    assign in_ch    = s_tdata[2:0];
    assign in_value = s_tdata[18:3];

    assign s_tready = !r_m_valid || m_tready;
    assign acc      = s_tvalid && s_tready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = paddr[2] ? {{(32-STEP_W){1'b0}}, r_step}
                             : {{(32-WIDTH_W){1'b0}}, r_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= SLOT_RESET;
            r_step <= STEP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2]) r_step <= pwdata[STEP_W-1:0];
            else          r_slot <= pwdata[WIDTH_W-1:0];
        end
    end

    // status beat shows the post-update view, so take each lane's next state
    genvar g;
    generate
        for (g = 0; g < CHANNELS; g++) begin : g_lane
            assign lane_ctl[g].sel   = acc && (in_cmd == CMD_MOVE || in_cmd == CMD_SET)
                                       && (32'(in_ch) == g);
            assign lane_ctl[g].set   = in_cmd == CMD_SET;
            assign lane_ctl[g].ramp  = acc && in_cmd == CMD_RAMP;
            assign lane_ctl[g].value = in_value;
            assign lane_ctl[g].step  = r_step;
            assign act_n[g]          = lane_n[g].active;

            ssp_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (lane_ctl[g]),
                .o_state (lane_q[g]),
                .o_next  (lane_n[g])
            );
        end
    endgenerate

    assign tick_inc = r_tick + 1'b1;

    always_comb begin
        n_tick  = r_tick;
        n_cur   = r_cur;
        n_latch = r_latch;
        n_line  = r_line;
        if (acc && in_cmd == CMD_TICK) begin
            n_tick = tick_inc;
            if (tick_inc == r_slot) begin
                n_tick  = '0;
                n_line  = 1'b1;
                n_latch = lane_q[r_cur].width;
            end else if (r_line && tick_inc >= r_latch) begin
                n_line = 1'b0;
                n_cur  = (32'(r_cur) == CHANNELS - 1) ? '0 : r_cur + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= '0;
            r_cur   <= '0;
            r_latch <= '0;
            r_line  <= 1'b0;
        end else begin
            r_tick  <= n_tick;
            r_cur   <= n_cur;
            r_latch <= n_latch;
            r_line  <= n_line;
        end
    end

    assign act_pad = {8'b0, act_n};
    assign cur_pad = {3'b0, n_cur};

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            lines[i] = n_line && (32'(n_cur) == i);
        end
    end

    assign n_m_data = {5'b0, act_pad[7:0], cur_pad[2:0], lines};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (acc) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_m_data <= n_m_data;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sequential servo pulse generator. A queue of
// command beats feeds a clocked stream driver; a clocked monitor runs a
// cycle-free servo model on every accepted command and compares each status
// beat field by field. Slot period and ramp step are programmed over APB
// between phases, including the extremes. Source and sink idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import ssp_pkg::*;

    localparam int unsigned NCH = CHANNELS_DEF;

    typedef enum logic [2:0] {
        REG_SLOT_PERIOD = 3'd0,
        REG_STEP_SIZE   = 3'd1
    } t_reg_idx;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CHSEL_W-1:0] chan;
        logic [WIDTH_W-1:0] value;
    } t_servo_cmd;

    typedef struct packed {
        logic [NCH-1:0] moving;
        logic [2:0]     slot;
        logic [NCH-1:0] lines;
    } t_servo_status;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // channel[2:0], value[18:3], zero[23:19]
    logic [1:0]  s_tuser;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // servo_lines[7:0], slot_channel[10:8],
                            // moving_mask[18:11], zero[23:19]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sequential_servo_pulse_generator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // servo model state and register mirror
    logic [WIDTH_W-1:0] cfg_slot;
    logic [STEP_W-1:0]  cfg_step;
    logic [WIDTH_W-1:0] tick_cnt;
    logic [2:0]         cur_ch;
    logic [WIDTH_W-1:0] held_width;
    logic               pulse_on;
    logic [WIDTH_W-1:0] widths [NCH];
    logic [WIDTH_W-1:0] targets [NCH];
    logic [NCH-1:0]     ramping;
    logic [NCH-1:0]     rising;

    t_servo_cmd    pending_cmds [$];
    t_servo_status status_expected [$];

    int  mismatches;
    int  statuses_checked;
    int  cmd_count [4];
    int  reg_writes;
    int  beats_planned;
    int  src_idle_pct;
    int  snk_stall_pct;
    logic cmd_taken;

    initial begin
        i_clk = 1'b0;
    end

    always #2 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic t_servo_status servo_advance(input t_servo_cmd c);
        t_servo_status      st;
        logic [WIDTH_W:0]   sum;
        case (c.cmd)
            CMD_TICK: begin
                tick_cnt = tick_cnt + 1'b1;
                if (tick_cnt == cfg_slot) begin
                    tick_cnt   = '0;
                    pulse_on   = 1'b1;
                    held_width = widths[cur_ch];
                end else if (pulse_on && tick_cnt >= held_width) begin
                    pulse_on = 1'b0;
                    cur_ch   = cur_ch + 1'b1;
                end
            end
            CMD_RAMP: begin
                for (int i = 0; i < NCH; i++) begin
                    if (ramping[i]) begin
                        if (rising[i]) begin
                            sum = {1'b0, widths[i]} + cfg_step;
                            widths[i] = sum[WIDTH_W] ? '1 : sum[WIDTH_W-1:0];
                            if (widths[i] >= targets[i]) ramping[i] = 1'b0;
                        end else begin
                            widths[i] = (widths[i] > cfg_step) ? widths[i] - cfg_step : '0;
                            if (widths[i] <= targets[i]) ramping[i] = 1'b0;
                        end
                    end
                end
            end
            default: begin
                targets[c.chan] = c.value;
                if (c.cmd == CMD_SET) begin
                    widths[c.chan]  = c.value;
                    ramping[c.chan] = 1'b0;
                end else if (c.value == widths[c.chan]) begin
                    ramping[c.chan] = 1'b0;
                end else begin
                    ramping[c.chan] = 1'b1;
                    rising[c.chan]  = c.value > widths[c.chan];
                end
            end
        endcase
        st.lines  = pulse_on ? (NCH'(1) << cur_ch) : '0;
        st.slot   = cur_ch;
        st.moving = ramping;
        return st;
    endfunction

    // stream driver: present a new beat once the previous one is taken
    always @(negedge i_clk) begin
        t_servo_cmd c;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || cmd_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                c = pending_cmds.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, c.value, c.chan};
                s_tuser  <= c.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: predict on accepted commands, check status beats
    always @(posedge i_clk) begin
        t_servo_cmd    c;
        t_servo_status got;
        t_servo_status want;
        cmd_taken <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                c.cmd   = s_tuser;
                c.chan  = s_tdata[2:0];
                c.value = s_tdata[18:3];
                cmd_count[c.cmd]++;
                status_expected.push_back(servo_advance(c));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[18:0];
                if (status_expected.size() == 0) begin
                    flag_mismatch("unexpected status beat", 32'(m_tdata), 0);
                end else begin
                    want = status_expected.pop_front();
                    statuses_checked++;
                    if (got.lines !== want.lines)
                        flag_mismatch("servo_lines", 32'(got.lines), 32'(want.lines));
                    if (got.slot !== want.slot)
                        flag_mismatch("slot_channel", 32'(got.slot), 32'(want.slot));
                    if (got.moving !== want.moving)
                        flag_mismatch("moving_mask", 32'(got.moving), 32'(want.moving));
                end
            end
        end
    end

    task automatic apb_access(input t_reg_idx idx, input logic wr, input logic [31:0] data,
                              output logic [31:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx[0], 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input t_reg_idx idx, input logic [31:0] want);
        logic [31:0] rd;
        apb_access(idx, 1'b0, '0, rd);
        if (rd !== want) flag_mismatch(idx == REG_SLOT_PERIOD ? "slot_period readback" :
                                       "step_size readback", rd, want);
    endtask

    task automatic program_reg(input t_reg_idx idx, input logic [31:0] data);
        logic [31:0] rd;
        apb_access(idx, 1'b1, data, rd);
        if (idx == REG_SLOT_PERIOD) cfg_slot = data[WIDTH_W-1:0];
        else cfg_step = data[STEP_W-1:0];
        reg_writes++;
        check_reg(idx, idx == REG_SLOT_PERIOD ? 32'(cfg_slot) : 32'(cfg_step));
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || s_tvalid || status_expected.size() != 0)
            @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int unsigned chan,
                            input int unsigned value);
        t_servo_cmd c;
        c.cmd   = cmd;
        c.chan  = chan[CHSEL_W-1:0];
        c.value = value[WIDTH_W-1:0];
        pending_cmds.push_back(c);
        beats_planned++;
    endtask

    task automatic push_ticks(input int n);
        repeat (n) push_cmd(CMD_TICK, 0, 0);
    endtask

    function automatic int unsigned pick_width();
        int unsigned span;
        span = (cfg_slot == 0 || cfg_slot == 16'hFFFF) ? 65535 : cfg_slot + 1;
        if ($urandom_range(99) < 85) return $urandom_range(0, span);
        return $urandom_range(0, 65535);
    endfunction

    task automatic random_mix(input int n);
        int start;
        int r;
        start = beats_planned;
        while (beats_planned - start < n) begin
            r = $urandom_range(99);
            if (r < 50) begin
                push_ticks($urandom_range(1, 4));
            end else if (r < 60) begin
                push_cmd(CMD_SET, $urandom_range(0, 7), pick_width());
            end else if (r < 74) begin
                // move, then ramp it in with timer ticks interleaved
                push_cmd(CMD_MOVE, $urandom_range(0, 7), pick_width());
                repeat ($urandom_range(1, 6)) begin
                    push_cmd(CMD_RAMP, 0, 0);
                    if ($urandom_range(1)) push_cmd(CMD_TICK, 0, 0);
                end
            end else if (r < 79) begin
                push_cmd(CMD_MOVE, $urandom_range(0, 7), $urandom_range(1) ? 65535 : 0);
            end else if (r < 92) begin
                push_cmd(CMD_RAMP, $urandom_range(0, 7), $urandom_range(0, 65535));
            end else begin
                push_cmd($urandom_range(1) ? CMD_MOVE : CMD_TICK, $urandom_range(0, 7),
                         $urandom_range(0, 65535));
            end
        end
    endtask

    // lowering the period below the running count would need a full wrap,
    // so run the current slot out first
    task automatic align_slot(input logic [WIDTH_W-1:0] next_slot);
        int unsigned cur_span;
        wait_idle();
        cur_span = (cfg_slot == 0) ? 65536 : cfg_slot;
        if (next_slot != 0 && tick_cnt >= next_slot) begin
            push_ticks(cur_span - tick_cnt);
            wait_idle();
        end
    endtask

    task automatic run_phase(input logic [WIDTH_W-1:0] slot, input logic [STEP_W-1:0] step,
                             input int src_idle, input int snk_stall, input int n);
        align_slot(slot);
        program_reg(REG_SLOT_PERIOD, 32'(slot));
        program_reg(REG_STEP_SIZE, 32'(step));
        src_idle_pct  = src_idle;
        snk_stall_pct = snk_stall;
        random_mix(n);
    endtask

    initial begin
        forever begin
            #2_000_000;
            $display("timeout with %0d beats queued, %0d status beats outstanding",
                     pending_cmds.size(), status_expected.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b1;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        cmd_taken = 1'b0;
        mismatches = 0;
        statuses_checked = 0;
        reg_writes = 0;
        beats_planned = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        cmd_count = '{default: 0};
        cfg_slot   = SLOT_RESET;
        cfg_step   = STEP_RESET;
        tick_cnt   = '0;
        cur_ch     = '0;
        held_width = '0;
        pulse_on   = 1'b0;
        ramping    = '0;
        rising     = '0;
        for (int i = 0; i < NCH; i++) begin
            widths[i]  = WIDTH_RESET;
            targets[i] = WIDTH_RESET;
        end
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        check_reg(REG_SLOT_PERIOD, 32'(SLOT_RESET));
        check_reg(REG_STEP_SIZE, 32'(STEP_RESET));

        // directed: short slots, widest step
        program_reg(REG_SLOT_PERIOD, 3);
        program_reg(REG_STEP_SIZE, 4095);
        push_cmd(CMD_SET, 0, 0);
        push_cmd(CMD_SET, 1, 65535);
        push_ticks(3);
        push_ticks(1);
        push_ticks(2);
        push_ticks(3);
        push_cmd(CMD_SET, 1, 2);
        push_ticks(3);
        push_ticks(2);
        push_cmd(CMD_SET, 7, 64000);
        push_cmd(CMD_MOVE, 7, 65535);
        push_cmd(CMD_MOVE, 2, 0);
        push_cmd(CMD_MOVE, 4, 3000);
        push_cmd(CMD_SET, 4, 5);
        push_cmd(CMD_MOVE, 3, 1500);
        push_cmd(CMD_RAMP, 0, 0);

        run_phase(12, 3, 0, 0, 300);
        run_phase(20, 1, 81, 0, 250);
        run_phase(1, 4095, 0, 81, 200);
        run_phase(9, 100, 24, 24, 300);
        run_phase(16, 7, 0, 0, 150);
        wait_idle();
        random_mix(100);
        run_phase(16'hFFFF, 2000, 0, 0, 25);
        run_phase(0, 0, 24, 24, 25);

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("covered %0d ticks, %0d moves, %0d width sets, %0d ramp ticks",
                 cmd_count[CMD_TICK], cmd_count[CMD_MOVE], cmd_count[CMD_SET],
                 cmd_count[CMD_RAMP]);
        $display("%0d status beats compared across %0d register writes, %0d mismatches",
                 statuses_checked, reg_writes, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
